[rtl/core/lpfc_pkg.sv]
// ----------------------------------------------------------------------------
// lpfc_pkg: shared types and constants for the LP feasibility checker
// Command and sense codes, the queued operation record and the tolerance
// comparison used by both the front and the back.
// ----------------------------------------------------------------------------
package lpfc_pkg;

  localparam int MAX_ROWS_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 64;
  localparam int TOL_BITS       = 40;
  localparam int ROW_BITS       = 10;
  localparam int COUNT_BITS     = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 40'd4295;

  typedef enum logic [1:0] {
    CMD_VAR,
    CMD_NZ,
    CMD_ROW,
    CMD_FIN
  } cmd_t;

  typedef enum logic [1:0] {
    SENSE_LE,
    SENSE_GE,
    SENSE_EQ,
    SENSE_UNK
  } sense_t;

  typedef struct packed {
    cmd_t                kind;
    logic signed [63:0]  value;
    logic [ROW_BITS-1:0] row;
    logic                row_ok;
    sense_t              sense;
    logic [1:0]          found;
  } op_t;

  // true when a - b > tol, exact
  function automatic logic exceeds(logic signed [63:0] a, logic signed [63:0] b,
                                   logic [TOL_BITS-1:0] tol);
    logic [64:0] diff;
    diff = {a[63], a} - {b[63], b};
    return !diff[64] && (diff[63:0] > {24'b0, tol});
  endfunction

endpackage

[rtl/core/lp_solution_feasibility_check_top.sv]
// ----------------------------------------------------------------------------
// lp_solution_feasibility_check_top: LP solution feasibility checker
// Streams variables, nonzeros and rows in column order and counts violations.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one item per handshake; the output
// channel (out_valid/out_ready) returns exactly one result per item, in order.
// The tolerance register is written with cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// The front classifies an item in the cycle it is taken and pushes it into a
// two-entry queue; the back executes one item at a time, a variable or a
// finish with no further work, a row with its compare, a nonzero with
// four passes of one 32x32 multiplier plus a final add, round, then
// read-add-write of the activity store; the last step loads the result
// register.
// After reset, and after every finish item, the back sweeps all MAX_ROWS
// entries of the activity store clear and takes no item from the queue; the
// front still fills the queue and configuration writes are taken as ever.
// When the receiver stalls the result register holds, the back waits with its
// next result and the queue then fills, after which in_ready falls.
// ----------------------------------------------------------------------------
module lp_solution_feasibility_check_top #(
  parameter int MAX_ROWS   = lpfc_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = lpfc_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lpfc_pkg::TOL_BITS-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [63:0]                value,
  input  logic signed [63:0]                lower_bound,
  input  logic signed [63:0]                upper_bound,
  input  logic                              lower_infinite,
  input  logic                              upper_infinite,
  input  logic [lpfc_pkg::ROW_BITS-1:0]     row,
  input  logic [1:0]                        sense,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        item_violations,
  output logic [lpfc_pkg::COUNT_BITS-1:0]   total_violations,
  output logic                              finished
);

  logic [lpfc_pkg::TOL_BITS-1:0] tolerance;
  logic                          q_push, q_ready, q_pop, q_valid;
  lpfc_pkg::op_t                 push_op, pop_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= lpfc_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  lpfc_front #(.MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .value         (value),
    .lower_bound   (lower_bound),
    .upper_bound   (upper_bound),
    .lower_infinite(lower_infinite),
    .upper_infinite(upper_infinite),
    .row           (row),
    .sense         (sense),
    .tolerance     (tolerance),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_op          (push_op)
  );

  lpfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (push_op),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_op    (pop_op)
  );

  lpfc_back #(.MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .tolerance       (tolerance),
    .q_valid         (q_valid),
    .q_op            (pop_op),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .item_violations (item_violations),
    .total_violations(total_violations),
    .finished        (finished)
  );

endmodule

[rtl/core/lpfc_ram.sv]
// ----------------------------------------------------------------------------
// lpfc_ram: generic simple dual-port RAM
// One write port and one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module lpfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lpfc_queue.sv]
// ----------------------------------------------------------------------------
// lpfc_queue: short operation queue between front and back
// Register FIFO of decoded items; lets each side stall on its own.
// ----------------------------------------------------------------------------
module lpfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpfc_pkg::op_t push_op,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output lpfc_pkg::op_t pop_op
);

  localparam int DEPTH = lpfc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  lpfc_pkg::op_t entry [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entry[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_op;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop_valid) else $error("pop valid on empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

[rtl/core/lpfc_front.sv]
// ----------------------------------------------------------------------------
// lpfc_front: item intake and classification
// Narrows values to the value width, checks variable bounds, flags row range
// and hands a decoded operation to the queue.
// ----------------------------------------------------------------------------
module lpfc_front #(
  parameter int MAX_ROWS   = lpfc_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = lpfc_pkg::VALUE_BITS_DEF
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic signed [63:0]                  value,
  input  logic signed [63:0]                  lower_bound,
  input  logic signed [63:0]                  upper_bound,
  input  logic                                lower_infinite,
  input  logic                                upper_infinite,
  input  logic [lpfc_pkg::ROW_BITS-1:0]       row,
  input  logic [1:0]                          sense,
  input  logic [lpfc_pkg::TOL_BITS-1:0]       tolerance,
  input  logic                                q_ready,
  output logic                                q_push,
  output lpfc_pkg::op_t                       q_op
);

  localparam int SH = 64 - VALUE_BITS;

  logic [63:0]        v_sh, lo_sh, hi_sh;
  logic signed [63:0] v, lo, hi;
  logic               lo_bad, hi_bad;
  lpfc_pkg::cmd_t     kind;

  // keep the low value bits as two's complement
  assign v_sh  = value << SH;
  assign lo_sh = lower_bound << SH;
  assign hi_sh = upper_bound << SH;
  assign v     = $signed(v_sh) >>> SH;
  assign lo    = $signed(lo_sh) >>> SH;
  assign hi    = $signed(hi_sh) >>> SH;

  assign kind   = lpfc_pkg::cmd_t'(cmd);
  assign lo_bad = !lower_infinite && lpfc_pkg::exceeds(lo, v, tolerance);
  assign hi_bad = !upper_infinite && lpfc_pkg::exceeds(v, hi, tolerance);

  assign in_ready = q_ready;
  assign q_push   = in_valid;

  always_comb begin
    q_op        = '0;
    q_op.kind   = kind;
    q_op.value  = v;
    q_op.row    = row;
    q_op.row_ok = (32'(row) < 32'(MAX_ROWS));
    q_op.sense  = lpfc_pkg::sense_t'(sense);
    q_op.found  = (kind == lpfc_pkg::CMD_VAR) ? ({1'b0, lo_bad} + {1'b0, hi_bad}) : 2'd0;
  end

endmodule

[rtl/core/lpfc_back.sv]
// ----------------------------------------------------------------------------
// lpfc_back: execution of queued operations
// Multi-cycle Q32.32 product, row activity store, row checks, violation
// count, result register and the clearing sweep of the activity store.
// ----------------------------------------------------------------------------
module lpfc_back #(
  parameter int MAX_ROWS   = lpfc_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = lpfc_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lpfc_pkg::TOL_BITS-1:0]     tolerance,
  input  logic                              q_valid,
  input  lpfc_pkg::op_t                     q_op,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        item_violations,
  output logic [lpfc_pkg::COUNT_BITS-1:0]   total_violations,
  output logic                              finished
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [63:0] LIM1 = 64'(1) << (VALUE_BITS - 1);
  localparam logic [63:0] VMAX = LIM1 - 64'(1);
  localparam logic [63:0] VMIN = ~VMAX;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RND,
    S_ACC,
    S_ROWCMP,
    S_DONE
  } state_t;

  state_t                          state;
  lpfc_pkg::op_t                   cur;
  logic signed [63:0]              x;
  logic [lpfc_pkg::COUNT_BITS-1:0] count;
  logic [AW-1:0]                   clr_addr;
  logic [1:0]                      res_found;
  logic [63:0]                     ma, mb;
  logic                            neg;
  logic [2:0]                      step;
  logic [63:0]                     pp;
  logic [1:0]                      pp_sh;
  logic [127:0]                    acc;
  logic signed [63:0]              prod;

  logic                            out_free;
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [63:0]                     ram_wdata, ram_rdata;

  logic [31:0]                     a_half, b_half;
  logic [127:0]                    pp_ext;
  logic [64:0]                     lo2;
  logic [63:0]                     hi_r, mag_r;
  logic signed [63:0]              prod_next;
  logic signed [63:0]              base, act;
  logic signed [64:0]              sum;
  logic signed [63:0]              sum_sat;
  logic [1:0]                      row_found;
  logic [lpfc_pkg::COUNT_BITS:0]   cnt_sum;
  logic [lpfc_pkg::COUNT_BITS-1:0] count_next;

  lpfc_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_activity (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign ram_re    = q_pop;
  assign ram_raddr = AW'(q_op.row);

  // one 32x32 partial product per step, added in the step after
  assign a_half = step[0] ? ma[63:32] : ma[31:0];
  assign b_half = step[1] ? mb[63:32] : mb[31:0];
  assign pp_ext = {64'b0, pp} << {pp_sh, 5'b0};

  // round to nearest, ties away, then saturate to the value range
  always_comb begin
    lo2   = {1'b0, acc[63:0]} + 65'h0_8000_0000;
    hi_r  = acc[127:64] + 64'(lo2[64]);
    mag_r = (hi_r[63:32] != '0) ? '1 : {hi_r[31:0], lo2[63:32]};
    if (neg) begin
      prod_next = (mag_r >= LIM1) ? $signed(VMIN) : -$signed(mag_r);
    end else begin
      prod_next = (mag_r > VMAX) ? $signed(VMAX) : $signed(mag_r);
    end
  end

  always_comb begin
    base = cur.row_ok ? $signed(ram_rdata) : 64'sd0;
    sum  = {base[63], base} + {prod[63], prod};
    if (sum > $signed({VMAX[63], VMAX})) begin
      sum_sat = $signed(VMAX);
    end else if (sum < $signed({VMIN[63], VMIN})) begin
      sum_sat = $signed(VMIN);
    end else begin
      sum_sat = sum[63:0];
    end
  end

  always_comb begin
    act = cur.row_ok ? $signed(ram_rdata) : 64'sd0;
    unique case (cur.sense)
      lpfc_pkg::SENSE_LE:  row_found = {1'b0, lpfc_pkg::exceeds(act, cur.value, tolerance)};
      lpfc_pkg::SENSE_GE:  row_found = {1'b0, lpfc_pkg::exceeds(cur.value, act, tolerance)};
      lpfc_pkg::SENSE_EQ:  row_found = {1'b0, lpfc_pkg::exceeds(act, cur.value, tolerance) ||
                                              lpfc_pkg::exceeds(cur.value, act, tolerance)};
      default:             row_found = 2'd1;
    endcase
  end

  always_comb begin
    cnt_sum    = {1'b0, count} + (lpfc_pkg::COUNT_BITS + 1)'(res_found);
    count_next = cnt_sum[lpfc_pkg::COUNT_BITS] ? '1 : cnt_sum[lpfc_pkg::COUNT_BITS-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_ACC) begin
      ram_we    = cur.row_ok;
      ram_waddr = AW'(cur.row);
      ram_wdata = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      x         <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded or held below
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAX_ROWS - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_op;
            res_found <= q_op.found;
            ma        <= q_op.value[63] ? 64'(-q_op.value) : q_op.value;
            mb        <= x[63] ? 64'(-x) : x;
            neg       <= q_op.value[63] ^ x[63];
            step      <= '0;
            acc       <= '0;
            unique case (q_op.kind)
              lpfc_pkg::CMD_VAR: begin
                x     <= q_op.value;
                state <= S_DONE;
              end
              lpfc_pkg::CMD_NZ:  state <= S_MUL;
              lpfc_pkg::CMD_ROW: state <= S_ROWCMP;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_MUL: begin
          if (step != 3'd4) begin
            pp    <= 64'(a_half) * 64'(b_half);
            pp_sh <= 2'(step[0]) + 2'(step[1]);
          end
          if (step != 3'd0) begin
            acc <= acc + pp_ext;
          end
          step <= step + 1'b1;
          if (step == 3'd4) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          prod  <= prod_next;
          state <= S_ACC;
        end
        S_ACC: begin
          res_found <= 2'd0;
          state     <= S_DONE;
        end
        S_ROWCMP: begin
          res_found <= row_found;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            item_violations  <= res_found;
            total_violations <= count_next;
            finished         <= (cur.kind == lpfc_pkg::CMD_FIN);
            if (cur.kind == lpfc_pkg::CMD_FIN) begin
              count    <= '0;
              x        <= '0;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              count <= count_next;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE)) else $error("queue popped while busy");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (ram_we && ram_wdata == '0))
    else $error("clearing sweep wrote non-zero data");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && cur.kind == lpfc_pkg::CMD_FIN)
      |=> (count == '0 && state == S_CLEAR && finished))
    else $error("finish did not clear state");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule
